[src/swrl_pkg.sv]
package swrl_pkg;

  // Default sizing
  localparam int unsigned CLIENTS_DEF   = 16;
  localparam int unsigned LOG_DEPTH_DEF = 64;

  // Fixed field widths
  localparam int unsigned CLIENT_W  = 4;
  localparam int unsigned NOW_W     = 48;
  localparam int unsigned MAXREQ_W  = 7;
  localparam int unsigned WINDOW_W  = 27;
  localparam int unsigned CFG_W     = 27;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned INWIN_W   = 7;

  // Wide enough for any count or limit (LOG_DEPTH <= 1024)
  localparam int unsigned CMP_W = 11;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS    = 1'b1;

  // Register reset values
  localparam logic [MAXREQ_W-1:0] MAXREQ_RST = 7'd60;
  localparam logic [WINDOW_W-1:0] WINDOW_RST = 27'd60000;

  // Controller -> datapath
  typedef struct packed {
    logic clear_wr;   // write zero to the slot table at the sweep index
    logic load_req;   // capture request, read slot table
    logic load_meta;  // capture head/count, read oldest stamp
    logic pop;        // drop oldest stamp
    logic commit;     // decide, write back, load result register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic oor;
    logic meta_zero;
    logic stale;
    logic count_one;
  } status_t;

endpackage

[src/sliding_window_rate_limiter_core.sv]
// Channel   Valid         Stall          Payload
// request   in_valid_i    in_stall_o     client_id_i, now_ms_i
// result    out_valid_o   out_stall_i    allowed_o, in_window_o
// config    cfg_we_i      (none)         cfg_idx_i, cfg_wdata_i
//
// One request is in flight at a time. A transaction skips the expiry check when the
// client's log is empty or the slot is out of range; otherwise it drops each expired
// stamp from the head of the log in turn, and leaves the loop without checking again
// once every stamp has expired (one stamp-store read per cycle).
// After reset the slot table is swept to zero, and no request
// is taken meanwhile. The result sits in an output register, so a stalled
// result holds back the next decision but not the capture of the next request.
module sliding_window_rate_limiter_core #(
  parameter int unsigned CLIENTS   = swrl_pkg::CLIENTS_DEF,
  parameter int unsigned LOG_DEPTH = swrl_pkg::LOG_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [swrl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [swrl_pkg::CFG_W-1:0]     cfg_wdata_i,
  // request
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [swrl_pkg::CLIENT_W-1:0]  client_id_i,
  input  logic [swrl_pkg::NOW_W-1:0]     now_ms_i,
  // result
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           allowed_o,
  output logic [swrl_pkg::INWIN_W-1:0]   in_window_o
);

  swrl_pkg::cmd_t    cmd;
  swrl_pkg::status_t sts;

  // Sequencer: sweep, capture, head read, expiry loop, decide/write-back
  swrl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Registers, slot table, stamp store, stale compare, result register
  swrl_dpath #(
    .CLIENTS  (CLIENTS),
    .LOG_DEPTH(LOG_DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .client_id_i(client_id_i),
    .now_ms_i   (now_ms_i),
    .allowed_o  (allowed_o),
    .in_window_o(in_window_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

  // Only one request in flight: capture closes the input side
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while another is in flight");

  // An allowed request was logged, so its log is never empty
  a_allowed_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && allowed_o) |-> ((in_window_o != '0) || (LOG_DEPTH >= 128)))
    else $error("allowed result with empty log");

  // Log occupancy never exceeds its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (swrl_pkg::CMP_W'(in_window_o) <= swrl_pkg::CMP_W'(LOG_DEPTH)))
    else $error("log count above depth");

  // Sweep and commit never write the slot table together
  a_meta_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.clear_wr && cmd.commit))
    else $error("slot table write conflict");

endmodule

[src/swrl_ram.sv]
module swrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/swrl_ctrl.sv]
module swrl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output swrl_pkg::cmd_t    cmd_o,
  input  swrl_pkg::status_t sts_i
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_META   = 5'b00100,
    S_CHECK  = 5'b01000,
    S_DECIDE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_o.load_req = accept;
        if (accept) begin
          state_d = S_META;
        end
      end
      S_META: begin
        if (sts_i.oor) begin
          state_d = S_DECIDE;
        end else begin
          cmd_o.load_meta = 1'b1;
          state_d = sts_i.meta_zero ? S_DECIDE : S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.stale) begin
          cmd_o.pop = 1'b1;
          if (sts_i.count_one) begin
            state_d = S_DECIDE;
          end
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[src/swrl_dpath.sv]
module swrl_dpath #(
  parameter int unsigned CLIENTS   = swrl_pkg::CLIENTS_DEF,
  parameter int unsigned LOG_DEPTH = swrl_pkg::LOG_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [swrl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [swrl_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [swrl_pkg::CLIENT_W-1:0]  client_id_i,
  input  logic [swrl_pkg::NOW_W-1:0]     now_ms_i,
  output logic                           allowed_o,
  output logic [swrl_pkg::INWIN_W-1:0]   in_window_o,
  input  swrl_pkg::cmd_t                 cmd_i,
  output swrl_pkg::status_t              sts_o
);

  localparam int unsigned SLOT_W  = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int unsigned HEAD_W  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(LOG_DEPTH + 1);
  localparam int unsigned SUM_W   = COUNT_W + 1;
  localparam int unsigned META_W  = HEAD_W + COUNT_W;
  localparam int unsigned STORE_D = CLIENTS * LOG_DEPTH;
  localparam int unsigned ADDR_W  = (STORE_D > 1) ? $clog2(STORE_D) : 1;
  localparam int unsigned CMP_W   = swrl_pkg::CMP_W;

  // Configuration
  logic [swrl_pkg::MAXREQ_W-1:0] max_req_q;
  logic [swrl_pkg::WINDOW_W-1:0] window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_req_q <= swrl_pkg::MAXREQ_RST;
      window_q  <= swrl_pkg::WINDOW_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == swrl_pkg::REG_MAX_REQUESTS) begin
        max_req_q <= cfg_wdata_i[swrl_pkg::MAXREQ_W-1:0];
      end
      if (cfg_idx_i == swrl_pkg::REG_WINDOW_MS) begin
        window_q <= cfg_wdata_i[swrl_pkg::WINDOW_W-1:0];
      end
    end
  end

  // Slot table clearing sweep after reset
  logic [SLOT_W-1:0] clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clear_wr && !sts_o.clear_last) begin
      clr_idx_q <= clr_idx_q + 1'b1;
    end
  end

  // Request registers
  logic [SLOT_W-1:0]         slot_in;
  logic [SLOT_W-1:0]         slot_q;
  logic [ADDR_W-1:0]         base_q;
  logic [swrl_pkg::NOW_W-1:0] now_q;
  logic                      oor_q;
  logic [HEAD_W-1:0]         head_q;
  logic [COUNT_W-1:0]        cnt_q;

  assign slot_in = SLOT_W'(client_id_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      slot_q <= slot_in;
      base_q <= ADDR_W'(slot_in * LOG_DEPTH);
      now_q  <= now_ms_i;
      oor_q  <= (32'(client_id_i) >= 32'(CLIENTS));
    end
  end

  // Slot table: {head, count} per client
  logic [META_W-1:0]  meta_rd;
  logic [META_W-1:0]  meta_wd;
  logic [SLOT_W-1:0]  meta_wa;
  logic               meta_we;
  logic [HEAD_W-1:0]  meta_head;
  logic [COUNT_W-1:0] meta_cnt;

  assign meta_head = meta_rd[META_W-1:COUNT_W];
  assign meta_cnt  = meta_rd[COUNT_W-1:0];

  // Stamp store
  logic [swrl_pkg::NOW_W-1:0] stamp_rd;
  logic [ADDR_W-1:0]          stamp_ra;
  logic [ADDR_W-1:0]          stamp_wa;
  logic                       stamp_we;

  // Pointer arithmetic
  logic [HEAD_W-1:0]  head_inc;
  logic [SUM_W-1:0]   tail_sum;
  logic [HEAD_W-1:0]  tail;
  logic [CMP_W-1:0]   limit;
  logic               allow;
  logic [COUNT_W-1:0] cnt_new;

  assign head_inc = (head_q == HEAD_W'(LOG_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_sum = SUM_W'(head_q) + SUM_W'(cnt_q);
  assign tail     = (tail_sum >= SUM_W'(LOG_DEPTH)) ?
                    HEAD_W'(tail_sum - SUM_W'(LOG_DEPTH)) : HEAD_W'(tail_sum);

  // Limit saturates at the log depth
  assign limit = (CMP_W'(max_req_q) > CMP_W'(LOG_DEPTH)) ?
                 CMP_W'(LOG_DEPTH) : CMP_W'(max_req_q);
  assign allow   = !oor_q && (CMP_W'(cnt_q) < limit);
  assign cnt_new = allow ? cnt_q + 1'b1 : cnt_q;

  assign stamp_ra = cmd_i.load_meta ? base_q + ADDR_W'(meta_head)
                                    : base_q + ADDR_W'(head_inc);
  assign stamp_wa = base_q + ADDR_W'(tail);
  assign stamp_we = cmd_i.commit && allow;

  assign meta_we = cmd_i.clear_wr || (cmd_i.commit && !oor_q);
  assign meta_wa = cmd_i.clear_wr ? clr_idx_q : slot_q;
  assign meta_wd = cmd_i.clear_wr ? '0 : {head_q, cnt_new};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_meta) begin
      head_q <= meta_head;
      cnt_q  <= meta_cnt;
    end else if (cmd_i.pop) begin
      head_q <= head_inc;
      cnt_q  <= cnt_q - 1'b1;
    end
  end

  swrl_ram #(
    .WIDTH(META_W),
    .DEPTH(CLIENTS)
  ) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(meta_wa),
    .wdata_i(meta_wd),
    .re_i   (cmd_i.load_req),
    .raddr_i(slot_in),
    .rdata_o(meta_rd)
  );

  swrl_ram #(
    .WIDTH(swrl_pkg::NOW_W),
    .DEPTH(STORE_D)
  ) u_stamp_ram (
    .clk_i  (clk_i),
    .we_i   (stamp_we),
    .waddr_i(stamp_wa),
    .wdata_i(now_q),
    .re_i   (cmd_i.load_meta || cmd_i.pop),
    .raddr_i(stamp_ra),
    .rdata_o(stamp_rd)
  );

  // Result register
  logic                         allowed_q;
  logic [swrl_pkg::INWIN_W-1:0] in_window_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      allowed_q   <= allow;
      in_window_q <= oor_q ? '0 : swrl_pkg::INWIN_W'(cnt_new);
    end
  end

  assign allowed_o   = allowed_q;
  assign in_window_o = in_window_q;

  assign sts_o.clear_last = (clr_idx_q == SLOT_W'(CLIENTS - 1));
  assign sts_o.oor        = oor_q;
  assign sts_o.meta_zero  = (meta_cnt == '0);
  // stamp + window < now, done one bit wider so it cannot wrap
  assign sts_o.stale      = ({1'b0, stamp_rd} + (swrl_pkg::NOW_W + 1)'(window_q))
                            < {1'b0, now_q};
  assign sts_o.count_one  = (cnt_q == COUNT_W'(1));

endmodule
